// File: hw/rtl/vfp_pkg.sv
// vfp_pkg: shared types and constants of the vicp frame parser
package vfp_pkg;

    // symbol kinds from the tcp deframer
    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_SRC   = 3'd1;
    localparam logic [2:0] K_DST   = 3'd2;
    localparam logic [2:0] K_OTHER = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // result classes
    localparam logic [2:0] C_SKIP     = 3'd0;
    localparam logic [2:0] C_OPCODE   = 3'd1;
    localparam logic [2:0] C_VERSION  = 3'd2;
    localparam logic [2:0] C_SEQUENCE = 3'd3;
    localparam logic [2:0] C_RESERVED = 3'd4;
    localparam logic [2:0] C_LENGTH   = 3'd5;
    localparam logic [2:0] C_PAYLOAD  = 3'd6;
    localparam logic [2:0] C_ERROR    = 3'd7;

    // expected header bytes
    localparam logic [7:0] VERSION_OK  = 8'h01;
    localparam logic [7:0] RESERVED_OK = 8'h00;

    // default service port, 0x0745
    localparam logic [15:0] SERVICE_PORT_RST = {8'h07, 8'h45};

    // parser phases
    typedef enum logic [12:0] {
        PH_SRC  = 13'b0_0000_0000_0001,
        PH_DST  = 13'b0_0000_0000_0010,
        PH_HDR  = 13'b0_0000_0000_0100,
        PH_VER  = 13'b0_0000_0000_1000,
        PH_SEQ  = 13'b0_0000_0001_0000,
        PH_RSV  = 13'b0_0000_0010_0000,
        PH_LEN0 = 13'b0_0000_0100_0000,
        PH_LEN1 = 13'b0_0000_1000_0000,
        PH_LEN2 = 13'b0_0001_0000_0000,
        PH_LEN3 = 13'b0_0010_0000_0000,
        PH_PAY0 = 13'b0_0100_0000_0000,
        PH_PAY  = 13'b0_1000_0000_0000,
        PH_SEG  = 13'b1_0000_0000_0000
    } t_phase;

endpackage

// File: hw/rtl/vicp_frame_parser_unit.sv
// vicp_frame_parser_unit: classifies decoded tcp symbols into vicp frame fields
//
// Takes one decoded tcp symbol per cycle and returns one classified item for each.
// An accepted symbol is held in an input register, the parser state is
// updated from it by a single pass of logic and the item lands in the result register,
// and the sustained rate is one item per clock while nothing stalls. The input
// side stalls only while an input item is held and the result register is full and
// stalled downstream. The service port register may be written while no item is in flight.
module vicp_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_symbol_kind,
    input  logic [15:0] i_symbol_value,
    input  logic        i_from_receiver,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_field_class,
    output logic [7:0]  o_field_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic [31:0] o_frame_length,
    output logic        o_frame_from_receiver,
    output logic        o_header_bad
);

    // configuration and control registers
    logic [15:0]          r_service_port;
    logic                 r_in_vld;
    logic                 r_out_vld;

    // input register
    logic [2:0]           r_kind;
    logic [15:0]          r_value;
    logic                 r_dir;

    // parser state
    vfp_pkg::t_phase      r_phase, n_phase;
    logic                 r_chain, n_chain;
    logic [31:0]          r_rem,   n_rem;
    logic [31:0]          r_acc,   n_acc;
    logic                 r_cur_dir, n_cur_dir;

    // result register
    logic [2:0]           r_class,  n_class;
    logic [7:0]           r_byte,   n_byte;
    logic                 r_fstart, n_fstart;
    logic                 r_fend,   n_fend;
    logic                 r_bad,    n_bad;

    // working signals of the single pass
    vfp_pkg::t_phase      e_phase;
    logic                 e_chain;
    logic [31:0]          e_rem;
    logic [31:0]          e_acc;
    logic                 e_dir;
    logic                 is_data, is_src, is_dst, is_err;
    logic                 restart_pre;
    logic                 perr, pdone;
    logic [7:0]           sym_byte;
    logic [31:0]          acc_shift;
    logic                 rem_last;

    logic                 in_accept;
    logic                 advance;

    // handshake
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // symbol decode
    assign is_err    = r_kind[2];
    assign is_data   = (r_kind == vfp_pkg::K_DATA);
    assign is_src    = (r_kind == vfp_pkg::K_SRC);
    assign is_dst    = (r_kind == vfp_pkg::K_DST);
    assign sym_byte  = r_value[7:0];
    assign acc_shift = {e_acc[23:0], sym_byte};
    assign rem_last  = (e_rem[31:1] == 31'd0);

    // restart checks and resumption before the phase logic
    always_comb begin
        restart_pre = !is_err && (
            (((r_phase != vfp_pkg::PH_SRC) || r_chain) && (r_dir != r_cur_dir)) ||
            (r_chain && !is_data) ||
            ((r_phase != vfp_pkg::PH_SRC) && (r_phase != vfp_pkg::PH_PAY) && is_src));
        e_phase = r_phase;
        e_chain = r_chain;
        e_rem   = r_rem;
        e_acc   = r_acc;
        e_dir   = r_cur_dir;
        if (restart_pre) begin
            e_phase = vfp_pkg::PH_SRC;
            e_chain = 1'b0;
            e_rem   = 32'd0;
            e_acc   = 32'd0;
            e_dir   = r_dir;
        end else begin
            if ((r_phase == vfp_pkg::PH_SRC) && !r_chain) begin
                e_dir = r_dir;
            end
            // data after a finished frame opens the next one
            if (r_chain && is_data) begin
                e_phase = vfp_pkg::PH_HDR;
                e_chain = 1'b0;
            end
            // data after a new segment header resumes the payload
            if ((r_phase == vfp_pkg::PH_SEG) && is_data) begin
                e_phase = vfp_pkg::PH_PAY;
            end
        end
    end

    // phase logic
    always_comb begin
        n_phase   = e_phase;
        n_chain   = e_chain;
        n_rem     = e_rem;
        n_acc     = e_acc;
        n_cur_dir = e_dir;
        n_class   = vfp_pkg::C_SKIP;
        n_fstart  = 1'b0;
        n_fend    = 1'b0;
        n_bad     = 1'b0;
        n_byte    = is_data ? sym_byte : 8'd0;
        perr      = 1'b0;
        pdone     = 1'b0;

        unique case (e_phase)
            vfp_pkg::PH_DST: begin
                if (!is_dst || (r_dir && (r_value != r_service_port))) begin
                    perr = 1'b1;
                end else begin
                    n_phase = vfp_pkg::PH_HDR;
                end
            end
            vfp_pkg::PH_HDR: begin
                if (is_data) begin
                    n_class  = vfp_pkg::C_OPCODE;
                    n_fstart = 1'b1;
                    n_acc    = 32'd0;
                    n_rem    = 32'd0;
                    n_phase  = vfp_pkg::PH_VER;
                end
            end
            vfp_pkg::PH_VER: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_VERSION;
                    n_bad   = (sym_byte != vfp_pkg::VERSION_OK);
                    n_phase = vfp_pkg::PH_SEQ;
                end
            end
            vfp_pkg::PH_SEQ: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_SEQUENCE;
                    n_phase = vfp_pkg::PH_RSV;
                end
            end
            vfp_pkg::PH_RSV: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_RESERVED;
                    n_bad   = (sym_byte != vfp_pkg::RESERVED_OK);
                    n_phase = vfp_pkg::PH_LEN0;
                end
            end
            vfp_pkg::PH_LEN0: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_LENGTH;
                    n_acc   = {24'd0, sym_byte};
                    n_phase = vfp_pkg::PH_LEN1;
                end
            end
            vfp_pkg::PH_LEN1: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_LENGTH;
                    n_acc   = acc_shift;
                    n_rem   = acc_shift;
                    n_phase = vfp_pkg::PH_LEN2;
                end
            end
            vfp_pkg::PH_LEN2: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_LENGTH;
                    n_acc   = acc_shift;
                    n_rem   = acc_shift;
                    n_phase = vfp_pkg::PH_LEN3;
                end
            end
            vfp_pkg::PH_LEN3: begin
                if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_LENGTH;
                    n_acc   = acc_shift;
                    n_rem   = acc_shift;
                    // zero length ends the frame on its last length byte
                    if (acc_shift == 32'd0) begin
                        n_fend = 1'b1;
                        pdone  = 1'b1;
                    end else begin
                        n_phase = vfp_pkg::PH_PAY0;
                    end
                end
            end
            vfp_pkg::PH_PAY0, vfp_pkg::PH_PAY: begin
                if ((e_phase == vfp_pkg::PH_PAY) && is_src) begin
                    n_phase = vfp_pkg::PH_SEG;
                end else if (!is_data) begin
                    perr = 1'b1;
                end else begin
                    n_class = vfp_pkg::C_PAYLOAD;
                    n_phase = vfp_pkg::PH_PAY;
                    if (rem_last) begin
                        n_rem  = 32'd0;
                        n_fend = 1'b1;
                        pdone  = 1'b1;
                    end else begin
                        n_rem = e_rem - 32'd1;
                    end
                end
            end
            vfp_pkg::PH_SEG: begin
                // other headers of the new segment are skipped
                n_phase = vfp_pkg::PH_SEG;
            end
            default: begin
                // awaiting the source port
                if (!is_src || (!r_dir && (r_value != r_service_port))) begin
                    n_phase = vfp_pkg::PH_SRC;
                    perr    = 1'b1;
                end else begin
                    n_phase = vfp_pkg::PH_DST;
                end
            end
        endcase

        // outcome of the pass
        priority if (is_err || perr) begin
            n_phase   = vfp_pkg::PH_SRC;
            n_chain   = 1'b0;
            n_rem     = 32'd0;
            n_acc     = 32'd0;
            n_cur_dir = r_dir;
            n_class   = vfp_pkg::C_ERROR;
            n_bad     = 1'b0;
            n_fstart  = 1'b0;
            n_fend    = 1'b0;
        end else if (pdone) begin
            n_phase = vfp_pkg::PH_SRC;
            n_rem   = 32'd0;
            n_chain = 1'b1;
        end else begin
            n_chain = 1'b0;
        end
    end

    // control, configuration and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_port <= vfp_pkg::SERVICE_PORT_RST;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_phase        <= vfp_pkg::PH_SRC;
            r_chain        <= 1'b0;
            r_rem          <= 32'd0;
            r_acc          <= 32'd0;
            r_cur_dir      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_service_port <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_phase   <= n_phase;
                r_chain   <= n_chain;
                r_rem     <= n_rem;
                r_acc     <= n_acc;
                r_cur_dir <= n_cur_dir;
            end
        end
    end

    // input and result payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_symbol_kind;
            r_value <= i_symbol_value;
            r_dir   <= i_from_receiver;
        end
        if (advance) begin
            r_class  <= n_class;
            r_byte   <= n_byte;
            r_fstart <= n_fstart;
            r_fend   <= n_fend;
            r_bad    <= n_bad;
        end
    end

    // result item, length and direction follow the state after the item
    assign o_out_valid           = r_out_vld;
    assign o_field_class         = r_class;
    assign o_field_byte          = r_byte;
    assign o_frame_start         = r_fstart;
    assign o_frame_end           = r_fend;
    assign o_frame_length        = r_acc;
    assign o_frame_from_receiver = r_cur_dir;
    assign o_header_bad          = r_bad;

endmodule

// File: tb/testbench.sv
// testbench: randomised self-checking test of the vicp frame parser unit
`timescale 1ns / 1ps

module testbench;
    import vfp_pkg::*;

    // kinds above the error code are invalid and count as errors
    localparam logic [2:0] K_BAD_MAX = 3'd7;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 80;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        dir;
    } t_symbol;

    typedef struct packed {
        logic [2:0]  field_class;
        logic [7:0]  field_byte;
        logic        frame_start;
        logic        frame_end;
        logic [31:0] frame_length;
        logic        frame_dir;
        logic        header_bad;
    } t_field;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic [2:0]  symbol_kind = '0;
    logic [15:0] symbol_value = '0;
    logic        from_receiver = 1'b0;
    logic        out_stall = 1'b0;

    wire         o_in_stall;
    wire         o_out_valid;
    wire  [2:0]  o_field_class;
    wire  [7:0]  o_field_byte;
    wire         o_frame_start;
    wire         o_frame_end;
    wire  [31:0] o_frame_length;
    wire         o_frame_from_receiver;
    wire         o_header_bad;

    vicp_frame_parser_unit dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_symbol_kind         (symbol_kind),
        .i_symbol_value        (symbol_value),
        .i_from_receiver       (from_receiver),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_field_class         (o_field_class),
        .o_field_byte          (o_field_byte),
        .o_frame_start         (o_frame_start),
        .o_frame_end           (o_frame_end),
        .o_frame_length        (o_frame_length),
        .o_frame_from_receiver (o_frame_from_receiver),
        .o_header_bad          (o_header_bad)
    );

    // pending symbols and expected classified items
    t_symbol     symbol_queue[$];
    t_field      expected_fields[$];

    // parser state as predicted
    t_phase      parse_ph = PH_SRC;
    logic        chaining = 1'b0;
    logic [31:0] bytes_left = '0;
    logic [31:0] length_acc = '0;
    logic        frame_dir = 1'b0;
    logic [15:0] vicp_port = SERVICE_PORT_RST;

    int unsigned n_queued = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_frames = 0;
    int unsigned n_errors = 0;
    int unsigned n_bad_hdr = 0;
    int unsigned n_fail = 0;
    int unsigned quiet_cycles = 0;
    logic        no_idle = 1'b0;

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    function automatic void restart_parser(input logic dir);
        parse_ph = PH_SRC;
        chaining = 1'b0;
        bytes_left = '0;
        length_acc = '0;
        frame_dir = dir;
    endfunction

    // classify one symbol and update the predicted parser state
    function automatic t_field classify_symbol(input t_symbol sym);
        t_field     r;
        logic [7:0] b;
        logic       done, err, again, settled, advance;
        int         pass;
        r = '0;
        b = sym.value[7:0];
        settled = 1'b0;
        if (sym.kind >= K_ERR) begin
            restart_parser(sym.dir);
            r.field_class = C_ERROR;
        end else begin
            // a restart sends the same symbol round again from the idle phase
            for (pass = 0; pass < 4 && !settled; pass++) begin
                done = 1'b0;
                err = 1'b0;
                again = 1'b0;
                advance = 1'b0;
                if ((parse_ph != PH_SRC || chaining) && sym.dir != frame_dir) begin
                    restart_parser(sym.dir);
                end else if (chaining && sym.kind != K_DATA) begin
                    restart_parser(sym.dir);
                end else if (parse_ph != PH_SRC && parse_ph != PH_PAY && sym.kind == K_SRC) begin
                    restart_parser(sym.dir);
                end else begin
                    if (parse_ph == PH_SRC && !chaining)
                        frame_dir = sym.dir;
                    r.field_class = C_SKIP;
                    case (parse_ph)
                        PH_DST: begin
                            if (sym.kind != K_DST || (sym.dir && sym.value != vicp_port))
                                err = 1'b1;
                            else
                                parse_ph = PH_HDR;
                        end
                        PH_HDR: begin
                            if (sym.kind == K_DATA) begin
                                r.field_class = C_OPCODE;
                                r.frame_start = 1'b1;
                                length_acc = '0;
                                bytes_left = '0;
                                parse_ph = PH_VER;
                            end
                        end
                        PH_VER, PH_SEQ, PH_RSV, PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3,
                        PH_PAY0: begin
                            if (sym.kind != K_DATA) begin
                                err = 1'b1;
                            end else begin
                                advance = 1'b1;
                                case (parse_ph)
                                    PH_VER: begin
                                        r.field_class = C_VERSION;
                                        r.header_bad = (b != VERSION_OK);
                                    end
                                    PH_SEQ: r.field_class = C_SEQUENCE;
                                    PH_RSV: begin
                                        r.field_class = C_RESERVED;
                                        r.header_bad = (b != RESERVED_OK);
                                    end
                                    PH_LEN0: begin
                                        r.field_class = C_LENGTH;
                                        length_acc = {24'd0, b};
                                    end
                                    PH_LEN1, PH_LEN2, PH_LEN3: begin
                                        r.field_class = C_LENGTH;
                                        length_acc = {length_acc[23:0], b};
                                        bytes_left = length_acc;
                                        // zero length closes on the last length byte
                                        if (parse_ph == PH_LEN3 && bytes_left == 0) begin
                                            r.frame_end = 1'b1;
                                            done = 1'b1;
                                            advance = 1'b0;
                                        end
                                    end
                                    default: begin
                                        r.field_class = C_PAYLOAD;
                                        if (bytes_left <= 1) begin
                                            bytes_left = '0;
                                            r.frame_end = 1'b1;
                                            done = 1'b1;
                                            advance = 1'b0;
                                        end else begin
                                            bytes_left = bytes_left - 32'd1;
                                        end
                                    end
                                endcase
                                if (advance)
                                    parse_ph = t_phase'({parse_ph[11:0], 1'b0});
                            end
                        end
                        PH_PAY: begin
                            if (sym.kind == K_SRC) begin
                                parse_ph = PH_SEG;
                            end else if (sym.kind != K_DATA) begin
                                err = 1'b1;
                            end else begin
                                r.field_class = C_PAYLOAD;
                                if (bytes_left != 0)
                                    bytes_left = bytes_left - 32'd1;
                                if (bytes_left == 0) begin
                                    r.frame_end = 1'b1;
                                    done = 1'b1;
                                end
                            end
                        end
                        PH_SEG: begin
                            if (sym.kind == K_DATA) begin
                                parse_ph = PH_PAY;
                                again = 1'b1;
                            end
                        end
                        default: begin
                            if (sym.kind == K_DATA && chaining) begin
                                parse_ph = PH_HDR;
                                chaining = 1'b0;
                                again = 1'b1;
                            end else if (sym.kind != K_SRC || (!sym.dir && sym.value != vicp_port)) begin
                                parse_ph = PH_SRC;
                                err = 1'b1;
                            end else begin
                                parse_ph = PH_DST;
                            end
                        end
                    endcase
                    if (!again) begin
                        settled = 1'b1;
                        if (err) begin
                            restart_parser(sym.dir);
                            r.field_class = C_ERROR;
                            r.header_bad = 1'b0;
                        end else if (done) begin
                            parse_ph = PH_SRC;
                            bytes_left = '0;
                            chaining = 1'b1;
                        end else begin
                            chaining = 1'b0;
                        end
                    end
                end
            end
        end
        r.field_byte = (sym.kind == K_DATA) ? b : 8'd0;
        r.frame_length = length_acc;
        r.frame_dir = frame_dir;
        return r;
    endfunction

    function automatic t_symbol make_symbol(input logic [2:0] kind, input logic [15:0] value,
                                            input logic dir);
        return {kind, value, dir};
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : vicp_port;
    endfunction

    task automatic queue_symbol(input t_symbol sym);
        symbol_queue.insert(symbol_queue.size(), sym);
        n_queued++;
    endtask

    // one vicp frame, optionally broken by a stray symbol at a random point
    task automatic queue_frame(input logic dir, input bit chained);
        t_symbol     syms[$];
        int unsigned len, n_pay, pos;
        int          i;
        if (!chained) begin
            syms.insert(syms.size(),
                        make_symbol(K_SRC, dir ? 16'($urandom) : pick_port(), dir));
            syms.insert(syms.size(),
                        make_symbol(K_DST, dir ? pick_port() : 16'($urandom), dir));
            repeat ($urandom_range(0, 2))
                syms.insert(syms.size(), make_symbol(K_OTHER, 16'($urandom), dir));
        end
        syms.insert(syms.size(), make_symbol(K_DATA, 16'($urandom), dir));
        syms.insert(syms.size(), make_symbol(K_DATA, ($urandom_range(0, 7) == 0) ?
                    16'($urandom) : {8'($urandom), VERSION_OK}, dir));
        syms.insert(syms.size(), make_symbol(K_DATA, 16'($urandom), dir));
        syms.insert(syms.size(), make_symbol(K_DATA, ($urandom_range(0, 7) == 0) ?
                    16'($urandom) : {8'($urandom), RESERVED_OK}, dir));
        // mostly short payloads, now and then one that never completes
        case ($urandom_range(0, 9))
            0:       len = $urandom;
            1:       len = $urandom_range(13, 40);
            default: len = $urandom_range(0, 6);
        endcase
        for (i = 3; i >= 0; i--)
            syms.insert(syms.size(), make_symbol(K_DATA, {8'($urandom), len[8*i +: 8]}, dir));
        n_pay = (len > 40) ? $urandom_range(0, 8) : len;
        for (i = 0; i < n_pay; i++) begin
            // new tcp segment in the middle of the payload
            if (i > 0 && $urandom_range(0, 7) == 0) begin
                syms.insert(syms.size(), make_symbol(K_SRC, 16'($urandom), dir));
                repeat ($urandom_range(0, 2))
                    syms.insert(syms.size(),
                                make_symbol($urandom_range(0, 1) ? K_DST : K_OTHER,
                                            16'($urandom), dir));
            end
            syms.insert(syms.size(), make_symbol(K_DATA, 16'($urandom), dir));
        end
        if ($urandom_range(0, 6) == 0) begin
            pos = $urandom_range(0, syms.size() - 1);
            syms.insert(pos, make_symbol(3'($urandom_range(0, 7)), 16'($urandom),
                                         1'($urandom_range(0, 1))));
        end
        for (i = 0; i < syms.size(); i++)
            queue_symbol(syms[i]);
    endtask

    // mostly well formed frames, some back to back, the rest loose symbols
    task automatic queue_random(input int unsigned count);
        int unsigned stop;
        logic        dir;
        stop = n_queued + count;
        while (n_queued < stop) begin
            dir = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 75) begin
                queue_frame(dir, 1'b0);
                repeat ($urandom_range(0, 2))
                    if ($urandom_range(0, 1) == 1)
                        queue_frame(dir, 1'b1);
            end else begin
                repeat ($urandom_range(1, 6))
                    queue_symbol(make_symbol(3'($urandom_range(0, 7)), 16'($urandom),
                                             ($urandom_range(0, 3) == 0) ? ~dir : dir));
            end
        end
    endtask

    task automatic wait_drained();
        while (!(symbol_queue.size() == 0 && !in_valid && expected_fields.size() == 0))
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_service_port(input logic [15:0] port);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= port;
        vicp_port = port;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender: offers queued symbols with random gaps
    always @(posedge clk) begin : drive_symbols
        t_symbol     nxt;
        t_symbol     cur;
        logic        offer;
        int unsigned send_gap;
        int unsigned steady_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offer = in_valid;
            // no leftover gap once the full rate stretch begins
            if (no_idle)
                send_gap = 0;
            if (in_valid && !o_in_stall) begin
                cur = {symbol_kind, symbol_value, from_receiver};
                expected_fields.insert(expected_fields.size(), classify_symbol(cur));
                n_sent++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (symbol_queue.size() > 0) begin
                    nxt = symbol_queue.pop_front();
                    symbol_kind <= nxt.kind;
                    symbol_value <= nxt.value;
                    from_receiver <= nxt.dir;
                    offer = 1'b1;
                    if (steady_left > 0)
                        steady_left--;
                    else if (!no_idle && $urandom_range(0, 39) == 0)
                        steady_left = $urandom_range(20, 60);
                    else if (!no_idle && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 19);
                end
            end
            in_valid <= offer;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // receiver: checks each classified item and stalls in bursts
    always @(posedge clk) begin : collect_fields
        t_field      want;
        t_field      got;
        int unsigned stall_left;
        bit          long_hold_done;
        if (rst_n && o_out_valid && !out_stall) begin
            got = {o_field_class, o_field_byte, o_frame_start, o_frame_end, o_frame_length,
                   o_frame_from_receiver, o_header_bad};
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, got);
                n_fail++;
            end else begin
                want = expected_fields.pop_front();
                check_field("field_class", 32'(want.field_class), 32'(got.field_class));
                check_field("field_byte", 32'(want.field_byte), 32'(got.field_byte));
                check_field("frame_start", 32'(want.frame_start), 32'(got.frame_start));
                check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
                check_field("frame_length", want.frame_length, got.frame_length);
                check_field("frame_from_receiver", 32'(want.frame_dir), 32'(got.frame_dir));
                check_field("header_bad", 32'(want.header_bad), 32'(got.header_bad));
                if (want.frame_end)
                    n_frames++;
                if (want.field_class == C_ERROR)
                    n_errors++;
                if (want.header_bad)
                    n_bad_hdr++;
            end
            n_checked++;
        end
        // no leftover hold-off once the full rate stretch begins
        if (no_idle && long_hold_done)
            stall_left = 0;
        // one long hold-off so the parser backs up into its input
        if (stall_left > 0)
            stall_left--;
        else if (!long_hold_done && n_checked >= 150) begin
            stall_left = LONG_HOLD;
            long_hold_done = 1'b1;
        end else if (!no_idle && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 19);
        out_stall <= (stall_left > 0);
    end

    // progress monitor
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // stimulus sequence
    initial begin : run_test
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // tx frame with bad version and reserved bytes and zero length
        queue_symbol(make_symbol(K_SRC, SERVICE_PORT_RST, 1'b0));
        queue_symbol(make_symbol(K_DST, 16'hFFFF, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h00FF, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'hFF00, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h00AA, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h00FF, 1'b0));
        repeat (4) queue_symbol(make_symbol(K_DATA, 16'h0000, 1'b0));
        // chained frame of length one
        queue_symbol(make_symbol(K_DATA, 16'h0080, 1'b0));
        queue_symbol(make_symbol(K_DATA, {8'h00, VERSION_OK}, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h0055, 1'b0));
        queue_symbol(make_symbol(K_DATA, {8'h00, RESERVED_OK}, 1'b0));
        repeat (3) queue_symbol(make_symbol(K_DATA, 16'h0000, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h0001, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'hFF7E, 1'b0));
        // non-data symbol while chaining, then error and invalid kinds
        queue_symbol(make_symbol(K_OTHER, 16'hFFFF, 1'b0));
        queue_symbol(make_symbol(K_ERR, 16'h0000, 1'b1));
        queue_symbol(make_symbol(K_BAD_MAX, 16'hFFFF, 1'b1));
        // rx frame cut by a source port in the header, then a wrong port
        queue_symbol(make_symbol(K_SRC, 16'h0000, 1'b1));
        queue_symbol(make_symbol(K_DST, SERVICE_PORT_RST, 1'b1));
        queue_symbol(make_symbol(K_DATA, 16'h0001, 1'b1));
        queue_symbol(make_symbol(K_SRC, 16'hFFFF, 1'b1));
        queue_symbol(make_symbol(K_DST, 16'h0000, 1'b1));
        // direction change in the middle of a tcp header
        queue_symbol(make_symbol(K_SRC, SERVICE_PORT_RST, 1'b0));
        queue_symbol(make_symbol(K_DATA, 16'h0012, 1'b1));

        queue_random(80);
        wait_drained();
        write_service_port(16'h0000);
        queue_random(80);
        wait_drained();
        write_service_port(16'hFFFF);
        queue_random(80);
        wait_drained();
        write_service_port(16'($urandom));
        queue_random(70);
        wait_drained();
        // last stretch at full rate on both sides
        write_service_port(SERVICE_PORT_RST);
        no_idle <= 1'b1;
        queue_random(70);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d symbols and checked %0d items under five service port settings",
                 n_sent, n_checked);
        $display("%0d frames closed, %0d error items, %0d header faults",
                 n_frames, n_errors, n_bad_hdr);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
